/* design/mbe_pkg.sv */
package mbe_pkg;

    // Fixed-point format of all complex values.
    localparam int FRAC_BITS = 28;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 16;
    localparam int PROD_W    = 2 * DATA_W;

    // Reset value of the iteration limit.
    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = COUNT_W'(256);

    // Register map: index taken from paddr[2].
    localparam logic REG_MAX_ITER = 1'b0;

    // Escape bound of 2.0 at full precision.
    localparam logic signed [DATA_W+1:0] ESC_BOUND = (DATA_W+2)'(2) <<< FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RR,
        ST_MUL_II,
        ST_MUL_RI,
        ST_UPDATE,
        ST_DONE
    } mbe_state_t;

    // True when a component lies strictly outside [-2, 2].
    function automatic logic escaped(input logic [DATA_W-1:0] v);
        logic signed [DATA_W+1:0] s;
        begin
            s = (DATA_W+2)'(signed'(v));
            escaped = (s < -ESC_BOUND) || (s > ESC_BOUND);
        end
    endfunction

endpackage

/* design/mbe_fxmul.sv */
module mbe_fxmul
    import mbe_pkg::*;
(
    input  logic              clk,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] product
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_shifted;

    // Full 64-bit signed product.
    assign prod_next = PROD_W'(signed'(a)) * PROD_W'(signed'(b));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Drop the fraction bits and keep the low word.
    assign prod_shifted = prod_reg >>> FRAC_BITS;
    assign product      = prod_shifted[DATA_W-1:0];

endmodule

/* design/mandelbrot_escape_iterator.sv */
// Mandelbrot escape-time iterator, 32-bit fixed point with 28 fraction bits.
// Input stream s_*: one word per point c; tdata = {c_imag, c_real}.
// Output stream m_*: one word per point; tdata = {final_imag, final_real,
// iteration_count}. APB port: max_iterations at byte address 0.
// A single 32x32 multiplier is shared by the three products of z^2, so one
// z update steps through check and z_re^2, z_im^2, z_re*z_im, update.
// When a finished point raises m_tvalid, s_tready rises in the same cycle,
// so the next point can be taken then. The rate of points is set by the
// multiplier loop and the limit.
// s_tready is high only while the iterator is idle. The finished word sits
// in an output register, so a new point is accepted while it waits; if the
// receiver still holds off m_tready when the next point finishes, the
// iterator waits until the register is free.
// Reset clears the handshake state and sets max_iterations to 256.
// The user must write max_iterations only while no point is in flight; the block itself does not enforce it.
module mandelbrot_escape_iterator
    import mbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // [31:0] c_real, [63:32] c_imag
    // Output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [79:0]          m_tdata,   // [15:0] iteration_count,
                                            // [47:16] final_real, [79:48] final_imag
    // Configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    mbe_state_t         state_reg;
    mbe_state_t         state_next;

    logic [COUNT_W-1:0] max_iter_reg;
    logic [DATA_W-1:0]  zr_reg;
    logic [DATA_W-1:0]  zi_reg;
    logic [DATA_W-1:0]  cr_reg;
    logic [DATA_W-1:0]  ci_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]  rr_reg;
    logic [DATA_W-1:0]  ii_reg;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [DATA_W-1:0]  out_real_reg;
    logic [DATA_W-1:0]  out_imag_reg;

    logic               in_accept;
    logic               stop;
    logic               out_free;
    logic               load_out;
    logic [DATA_W-1:0]  mul_a;
    logic [DATA_W-1:0]  mul_b;
    logic [DATA_W-1:0]  mul_p;
    logic [DATA_W-1:0]  nr;
    logic [DATA_W-1:0]  ni;
    logic               cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_ITER);
    assign prdata    = (paddr[2] == REG_MAX_ITER) ? {16'b0, max_iter_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (cfg_write)
        begin
            max_iter_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Handshake and loop conditions.
    assign in_accept = s_tvalid && s_tready;
    assign stop      = !(cnt_reg < max_iter_reg) || escaped(zr_reg) || escaped(zi_reg);
    assign out_free  = !out_valid_reg || m_tready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_MUL_RR;
            ST_MUL_RR: state_next = stop ? ST_DONE : ST_MUL_II;
            ST_MUL_II: state_next = ST_MUL_RI;
            ST_MUL_RI: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_MUL_RR;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output decode: ready, multiplier operands and result load.
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        mul_a    = zr_reg;
        mul_b    = zi_reg;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_MUL_RR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            ST_MUL_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            ST_DONE:   load_out = out_free;
            default:   s_tready = 1'b0;
        endcase
    end

    // Shared fixed-point multiplier.
    mbe_fxmul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // New z: the cross product arrives in the update cycle.
    assign nr = rr_reg - ii_reg + cr_reg;
    assign ni = {mul_p[DATA_W-2:0], 1'b0} + ci_reg;

    // Iteration datapath.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cr_reg  <= s_tdata[31:0];
            ci_reg  <= s_tdata[63:32];
            zr_reg  <= s_tdata[31:0];
            zi_reg  <= s_tdata[63:32];
            cnt_reg <= COUNT_W'(1);
        end
        else
        begin
            case (state_reg)
                ST_MUL_II: rr_reg <= mul_p;
                ST_MUL_RI: ii_reg <= mul_p;
                ST_UPDATE:
                begin
                    zr_reg  <= nr;
                    zi_reg  <= ni;
                    cnt_reg <= cnt_reg + COUNT_W'(1);
                end
                default:   rr_reg <= rr_reg;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_count_reg <= cnt_reg;
            out_real_reg  <= zr_reg;
            out_imag_reg  <= zi_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_imag_reg, out_real_reg, out_count_reg};

endmodule

/* verif/mandelbrot_escape_iterator_tb.sv */
`timescale 1ns / 100ps

module mandelbrot_escape_iterator_tb;
    import mbe_pkg::*;

    localparam int          HALF_PERIOD    = 6;
    localparam int          STALL_LIMIT    = 800000;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [2:0]  MAX_ITER_ADDR  = {REG_MAX_ITER, 2'b00};
    // Random points mostly fall inside a box of about +/-2.25.
    localparam int          BOX_HALF       = 32'h2400_0000;
    localparam logic [31:0] TWO            = 32'h2000_0000;
    localparam logic [31:0] MINUS_TWO      = 32'hE000_0000;

    // One result word as predicted.
    typedef struct packed {
        logic [15:0] count;
        logic [31:0] z_re;
        logic [31:0] z_im;
    } escape_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;      // [31:0] c_real, [63:32] c_imag
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;            // [15:0] iteration_count, [47:16] final_real,
                                     // [79:48] final_imag
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    escape_t     pending_q[$];
    logic [15:0] iter_limit = MAX_ITER_RESET;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          mismatches = 0;
    int          points_sent = 0;
    int          points_inside = 0;
    int          words_checked = 0;
    int          quiet_cycles = 0;

    mandelbrot_escape_iterator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Fixed-point product: exact 64-bit product, arithmetic shift, low 32 bits kept.
    function automatic logic [31:0] fx_mul(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
        longint p;
        begin
            p = longint'(a) * longint'(b);
            p = p >>> FRAC_BITS;
            return p[31:0];
        end
    endfunction

    // A component escapes when it lies strictly outside [-2, 2].
    function automatic bit outside_bound(input logic signed [31:0] v);
        longint s;
        longint bound;
        begin
            s = longint'(v);
            bound = longint'(2) <<< FRAC_BITS;
            return (s < -bound) || (s > bound);
        end
    endfunction

    // Iterates z = z^2 + c from z = c until escape or the limit is reached.
    function automatic escape_t escape_time(input logic [31:0] cr, input logic [31:0] ci,
                                            input logic [15:0] limit);
        escape_t     r;
        logic [31:0] zr;
        logic [31:0] zi;
        logic [31:0] zr_next;
        int unsigned n;
        begin
            zr = cr;
            zi = ci;
            n = 1;
            while (n < limit) begin
                if (outside_bound(zr) || outside_bound(zi))
                    break;
                zr_next = fx_mul(zr, zr) - fx_mul(zi, zi) + cr;
                zi = (fx_mul(zr, zi) << 1) + ci;
                zr = zr_next;
                n++;
            end
            r.count = n[15:0];
            r.z_re = zr;
            r.z_im = zi;
            return r;
        end
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch in %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Check every result word against the oldest prediction.
    always @(posedge clk)
    begin : check_result
        escape_t want;
        if (rst_n && m_tvalid && m_tready) begin
            words_checked++;
            if (pending_q.size() == 0) begin
                note_mismatch("unexpected result word", '0, m_tdata[47:16]);
            end
            else begin
                want = pending_q.pop_front();
                if (m_tdata[15:0] !== want.count)
                    note_mismatch("iteration_count", 32'(want.count), 32'(m_tdata[15:0]));
                if (m_tdata[47:16] !== want.z_re)
                    note_mismatch("final_real", want.z_re, m_tdata[47:16]);
                if (m_tdata[79:48] !== want.z_im)
                    note_mismatch("final_imag", want.z_im, m_tdata[79:48]);
            end
        end
    end

    // Receiver holds off at random.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Watchdog on cycles where no handshake completes.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL mandelbrot_escape_iterator");
            $finish;
        end
    end

    // Send one point and record its prediction once it is taken.
    task automatic send_point(input logic [31:0] cr, input logic [31:0] ci);
        escape_t want;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ci, cr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = escape_time(cr, ci, iter_limit);
        pending_q.push_back(want);
        points_sent++;
        if (want.count == ((iter_limit == 0) ? 16'd1 : iter_limit))
            points_inside++;
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= MAX_ITER_ADDR;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the limit with random upper bits, then read it back.
    task automatic set_limit(input logic [15:0] limit);
        logic [31:0] rd;
        drain_results();
        apb_access(1'b1, {16'($urandom), limit}, rd);
        iter_limit = limit;
        apb_access(1'b0, '0, rd);
        if (rd !== {16'h0, limit})
            note_mismatch("max_iterations readback", {16'h0, limit}, rd);
    endtask

    function automatic logic [63:0] random_point();
        int pick;
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                return {$urandom, $urandom};
            if (pick < 15)
                return {($urandom_range(1) ? TWO : MINUS_TWO),
                        ($urandom_range(1) ? TWO : MINUS_TWO)};
            return {32'($urandom_range(2 * BOX_HALF) - BOX_HALF),
                    32'($urandom_range(2 * BOX_HALF) - BOX_HALF)};
        end
    endfunction

    // The limit after reset, seen by readback and by an inside point.
    task automatic test_reset_limit();
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== {16'h0, MAX_ITER_RESET})
            note_mismatch("max_iterations after reset", {16'h0, MAX_ITER_RESET}, rd);
        send_point(32'h0, 32'h0);
        send_point(32'h0400_0000, 32'h0800_0000);
    endtask

    // Most positive and most negative inputs escape at once; values next to zero stay in.
    task automatic test_field_extremes();
        set_limit(16'd40);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        send_point(32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    // Exactly 2 stays in, one step beyond escapes.
    task automatic test_escape_bound();
        send_point(TWO, 32'h0);
        send_point(MINUS_TWO, 32'h0);
        send_point(TWO + 1, 32'h0);
        send_point(32'h0, MINUS_TWO - 1);
        send_point(32'h0, MINUS_TWO);
    endtask

    // The doubled cross term and the sums wrap at 32 bits.
    task automatic test_wraparound();
        send_point(TWO, TWO);
        send_point(MINUS_TWO, MINUS_TWO);
        send_point(TWO, MINUS_TWO);
    endtask

    // A limit of zero behaves like a limit of one.
    task automatic test_zero_limit();
        set_limit(16'd0);
        send_point(32'h0, 32'h0);
        send_point(32'hF000_0000, 32'h0123_4567);
    endtask

    task automatic test_unit_limit();
        set_limit(16'd1);
        send_point(32'h0100_0000, 32'hFF00_0000);
        send_point(TWO, TWO);
    endtask

    // Largest limit: one point runs all the way, one escapes at once.
    task automatic test_full_limit();
        set_limit(16'hFFFF);
        send_point(32'h0, 32'h0);
        send_point(TWO + 1, 32'h0);
    endtask

    task automatic test_random_points(input int n, input int tx_pct, input int rx_pct,
                                      input logic [15:0] limit);
        logic [63:0] c;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        set_limit(limit);
        for (int i = 0; i < n; i++) begin
            c = random_point();
            send_point(c[31:0], c[63:32]);
            // Now and then let the pipeline run dry before going on.
            if ($urandom_range(99) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        tx_idle_pct = 16;
        rx_idle_pct = 46;
        test_reset_limit();
        test_field_extremes();
        test_escape_bound();
        test_wraparound();
        test_zero_limit();
        test_unit_limit();
        test_full_limit();
        test_random_points(345, 16, 46, 16'($urandom_range(2, 64)));
        test_random_points(345, 46, 16, 16'($urandom_range(65, 200)));
        test_random_points(345, 0, 0, 16'($urandom_range(1, 32)));
        rx_idle_pct = 0;
        drain_results();
        repeat (20) @(posedge clk);
        $display("Ran %0d points (%0d hit the limit, %0d escaped), %0d words checked,",
                 points_sent, points_inside, points_sent - points_inside, words_checked);
        $display("with limits 0, 1, 40, 256, 65535 and three random settings.");
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("PASS mandelbrot_escape_iterator");
        end
        else begin
            $display("%0d mismatches, %0d words missing", mismatches, pending_q.size());
            $display("FAIL mandelbrot_escape_iterator");
        end
        $finish;
    end

endmodule

/* mandelbrot_escape_iterator.f */
design/mbe_pkg.sv
design/mbe_fxmul.sv
design/mandelbrot_escape_iterator.sv
verif/mandelbrot_escape_iterator_tb.sv
